[sv/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants for the sphere / box contact pipeline.
// ----------------------------------------------------------------------------
package sac_pkg;

	// default coordinate width (Q16.16 words; the fraction count does not
	// enter the arithmetic)
	localparam int COORD_WIDTH_DEF = 32;

	// unit normal format, Q1.16
	localparam int NORM_FRAC  = 16;
	localparam int NORM_WIDTH = NORM_FRAC + 2;
	localparam logic signed [NORM_WIDTH-1:0] NORM_ONE = NORM_WIDTH'(1) <<< NORM_FRAC;

	// quotient bits of the normal divider: integer bit plus fraction
	localparam int DIV_STEPS_DEF = NORM_FRAC + 1;

endpackage

[sv/sac_isqrt.sv]
// ----------------------------------------------------------------------------
// sac_isqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
module sac_isqrt #(
	parameter int IN_W   = 66,
	parameter int ROOT_W = IN_W / 2
) (
	input  logic              clk,
	input  logic              ce,
	input  logic [IN_W-1:0]   rad,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;

	logic [IN_W-1:0]   n_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [IN_W-1:0]    n_in;
		logic [REM_W-1:0]   rem_in;
		logic [ROOT_W-1:0]  root_in;
		logic [REM_W+1:0]   rem4;
		logic [REM_W+1:0]   trial;
		logic [REM_W+1:0]   diff;
		logic               ge;

		if (k == 0) begin : g_first
			assign n_in    = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign n_in    = n_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign rem4  = {rem_in, n_in[IN_W-1 -: 2]};
		assign trial = {{(REM_W - ROOT_W){1'b0}}, root_in, 2'b01};
		assign ge    = rem4 >= trial;
		assign diff  = rem4 - trial;

		always_ff @(posedge clk) begin
			if (ce) begin
				n_s[k]    <= n_in << 2;
				rem_s[k]  <= ge ? diff[REM_W-1:0] : rem4[REM_W-1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

[sv/sac_udiv.sv]
// ----------------------------------------------------------------------------
// sac_udiv
// Pipelined restoring divider for one normal component:
// q = floor(num * 2^(STEPS-1) / den), num <= den.
// ----------------------------------------------------------------------------
module sac_udiv import sac_pkg::*; #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 33,
	parameter int STEPS = DIV_STEPS_DEF
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [STEPS-1:0] quo
);

	localparam int RM_W = DEN_W + 1;

	logic [RM_W-1:0]  rem_s [STEPS];
	logic [DEN_W-1:0] den_s [STEPS];
	logic [STEPS-1:0] q_s   [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [RM_W-1:0]  r_in;
		logic [DEN_W-1:0] d_in;
		logic [STEPS-1:0] q_in;
		logic [RM_W-1:0]  d_ext;
		logic             ge;

		if (k == 0) begin : g_first
			assign r_in = RM_W'(num);
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			// remainder stays below den, so one doubling fits
			assign r_in = {rem_s[k-1][DEN_W-1:0], 1'b0};
			assign d_in = den_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign d_ext = RM_W'(d_in);
		assign ge    = r_in >= d_ext;

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k] <= ge ? r_in - d_ext : r_in;
				den_s[k] <= d_in;
				q_s[k]   <= {q_in[STEPS-2:0], ge};
			end
		end
	end

	assign quo = q_s[STEPS-1];

endmodule

[sv/sphere_aabb_contact.sv]
// ----------------------------------------------------------------------------
// sphere_aabb_contact
// Sphere versus axis-aligned box contact: closest point, floored distance,
// penetration, unit normal and contact point, one request per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sphere, radius, box, half
//                                             tuser: sphere_is_second
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: penetration, normal, contact
//                                             tuser: hit
//
// Throughput: one request per cycle while the skid register is empty.
//   Path: box span, clamp, squares, squared distance, the bit-per-stage square
//   root, hit test, the bit-per-stage Q1.16 normal divider, output register.
// Stalls: the whole pipe holds while the output skid register is full; a
//   result waiting at the output does not block intake until the skid fills.
// Reset: arst_n clears only the valid bits and the output/skid flags.
//
module sphere_aabb_contact import sac_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
	// half_x, half_y, half_z (low bit up), zero padded
	input  logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_axis_tdata,
	// sphere_is_second
	input  logic s_axis_tuser,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// penetration, normal_x, normal_y, normal_z, contact_x, contact_y,
	// contact_z (low bit up), zero padded
	output logic [((4*COORD_WIDTH-1+3*NORM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// hit
	output logic m_axis_tuser
);

	localparam int CW        = COORD_WIDTH;
	localparam int RW        = CW - 1;
	localparam int SUM_W     = 2*CW + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int DIV_STEPS = DIV_STEPS_DEF;
	localparam int OUT_FW    = 4*CW - 1 + 3*NORM_WIDTH;
	localparam int OUT_W     = ((OUT_FW+7)/8)*8;
	localparam int OFS_BOX   = 3*CW + RW;
	localparam int OFS_HALF  = 6*CW + RW;

	// side data travelling next to the square root
	typedef struct packed {
		logic [2:0][CW-1:0] mag;
		logic [2:0]         neg;
		logic [2:0][CW-1:0] con;
		logic [RW-1:0]      rad;
		logic               sec;
	} geo_t;

	// side data travelling next to the dividers
	typedef struct packed {
		logic               hit;
		logic [RW-1:0]      pen;
		logic               zero;
		logic [2:0]         neg;
		logic [2:0][CW-1:0] con;
		logic               sec;
	} nrm_t;

	typedef struct packed {
		logic                                hit;
		logic [2:0][CW-1:0]                  con;
		logic [2:0][NORM_WIDTH-1:0]          nrm;
		logic [RW-1:0]                       pen;
	} res_t;

	// global advance: pipe holds only while the skid register is occupied
	logic ce;
	logic skid_valid_q;
	assign ce            = !skid_valid_q;
	assign s_axis_tready = ce;

	// ---------------- stage 1: box span ----------------
	logic                     v_s1;
	logic [2:0][CW-1:0]       sph_s1;
	logic [2:0][CW:0]         lo_s1;
	logic [2:0][CW:0]         hi_s1;
	logic [RW-1:0]            rad_s1;
	logic                     sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				sph_s1[k] <= s_axis_tdata[k*CW +: CW];
				lo_s1[k]  <= $signed({s_axis_tdata[OFS_BOX + k*CW + CW-1],
					s_axis_tdata[OFS_BOX + k*CW +: CW]}) -
					$signed({2'b00, s_axis_tdata[OFS_HALF + k*RW +: RW]});
				hi_s1[k]  <= $signed({s_axis_tdata[OFS_BOX + k*CW + CW-1],
					s_axis_tdata[OFS_BOX + k*CW +: CW]}) +
					$signed({2'b00, s_axis_tdata[OFS_HALF + k*RW +: RW]});
			end
			rad_s1 <= s_axis_tdata[3*CW +: RW];
			sec_s1 <= s_axis_tuser;
		end
	end

	// ---------------- stage 2: clamp, offset, saturated contact ----------------
	logic               v_s2;
	logic [2:0][CW:0]   d_s2;
	logic [2:0][CW-1:0] con_s2;
	logic [RW-1:0]      rad_s2;
	logic               sec_s2;

	logic [2:0][CW+1:0] dlo_c, dhi_c;
	logic [2:0][CW:0]   c_c;
	logic [2:0]         below_c, above_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dlo_c[k]   = $signed({{2{sph_s1[k][CW-1]}}, sph_s1[k]}) -
				$signed({lo_s1[k][CW], lo_s1[k]});
			dhi_c[k]   = $signed({{2{sph_s1[k][CW-1]}}, sph_s1[k]}) -
				$signed({hi_s1[k][CW], hi_s1[k]});
			below_c[k] = dlo_c[k][CW+1];
			above_c[k] = !dhi_c[k][CW+1] && (dhi_c[k] != '0);
			c_c[k]     = below_c[k] ? lo_s1[k] :
				(above_c[k] ? hi_s1[k] : {sph_s1[k][CW-1], sph_s1[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				// offset magnitude stays below 2^CW
				d_s2[k] <= below_c[k] ? dlo_c[k][CW:0] :
					(above_c[k] ? dhi_c[k][CW:0] : '0);
				if (c_c[k][CW] != c_c[k][CW-1])
					con_s2[k] <= c_c[k][CW] ? {1'b1, {(CW-1){1'b0}}}
						: {1'b0, {(CW-1){1'b1}}};
				else
					con_s2[k] <= c_c[k][CW-1:0];
			end
			rad_s2 <= rad_s1;
			sec_s2 <= sec_s1;
		end
	end

	// ---------------- stage 3: squares ----------------
	logic                 v_s3;
	logic [2:0][2*CW-1:0] sq_s3;
	geo_t                 geo_s3;

	logic [2:0][2*CW+1:0] prod_c;
	logic [2:0][CW:0]     neg_d_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k]  = $signed(d_s2[k]) * $signed(d_s2[k]);
			neg_d_c[k] = -d_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				sq_s3[k]      <= prod_c[k][2*CW-1:0];
				geo_s3.mag[k] <= d_s2[k][CW] ? neg_d_c[k][CW-1:0] : d_s2[k][CW-1:0];
				geo_s3.neg[k] <= d_s2[k][CW];
			end
			geo_s3.con <= con_s2;
			geo_s3.rad <= rad_s2;
			geo_s3.sec <= sec_s2;
		end
	end

	// ---------------- stage 4: squared distance ----------------
	logic             v_s4;
	logic [SUM_W-1:0] sum_s4;
	geo_t             geo_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			geo_s4 <= geo_s3;
		end
	end

	// ---------------- square root, one bit per stage ----------------
	logic [ROOT_W-1:0] dist_root;
	logic              sq_v_s   [ROOT_W];
	geo_t              sq_geo_s [ROOT_W];

	sac_isqrt #(
		.IN_W   (SUM_W),
		.ROOT_W (ROOT_W)
	) u_isqrt (
		.clk  (clk),
		.ce   (ce),
		.rad  (sum_s4),
		.root (dist_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++)
				sq_v_s[k] <= 1'b0;
		end else if (ce) begin
			sq_v_s[0] <= v_s4;
			for (int k = 1; k < ROOT_W; k++)
				sq_v_s[k] <= sq_v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq_geo_s[0] <= geo_s4;
			for (int k = 1; k < ROOT_W; k++)
				sq_geo_s[k] <= sq_geo_s[k-1];
		end
	end

	// ---------------- stage 5: hit test, penetration ----------------
	geo_t              g_last;
	logic              v_s5;
	nrm_t              nrm_s5;
	logic [2:0][CW-1:0] mag_s5;
	logic [ROOT_W-1:0] dist_s5;

	assign g_last = sq_geo_s[ROOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ce) begin
			v_s5 <= sq_v_s[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// touching is a miss; zero radius never hits
			nrm_s5.hit  <= dist_root < ROOT_W'(g_last.rad);
			nrm_s5.pen  <= g_last.rad - dist_root[RW-1:0];
			nrm_s5.zero <= dist_root == '0;
			nrm_s5.neg  <= g_last.neg;
			nrm_s5.con  <= g_last.con;
			nrm_s5.sec  <= g_last.sec;
			mag_s5      <= g_last.mag;
			dist_s5     <= dist_root;
		end
	end

	// ---------------- normal dividers, one quotient bit per stage ----------------
	logic [2:0][DIV_STEPS-1:0] quo;
	logic                      dv_v_s   [DIV_STEPS];
	nrm_t                      dv_side_s [DIV_STEPS];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		sac_udiv #(
			.NUM_W (CW),
			.DEN_W (ROOT_W),
			.STEPS (DIV_STEPS)
		) u_udiv (
			.clk (clk),
			.ce  (ce),
			.num (mag_s5[a]),
			.den (dist_s5),
			.quo (quo[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++)
				dv_v_s[k] <= 1'b0;
		end else if (ce) begin
			dv_v_s[0] <= v_s5;
			for (int k = 1; k < DIV_STEPS; k++)
				dv_v_s[k] <= dv_v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dv_side_s[0] <= nrm_s5;
			for (int k = 1; k < DIV_STEPS; k++)
				dv_side_s[k] <= dv_side_s[k-1];
		end
	end

	// ---------------- result assembly ----------------
	nrm_t fin;
	logic fin_valid;
	res_t res_c;

	assign fin       = dv_side_s[DIV_STEPS-1];
	assign fin_valid = dv_v_s[DIV_STEPS-1];

	always_comb begin
		logic signed [NORM_WIDTH-1:0] qs;
		logic signed [NORM_WIDTH-1:0] n;
		res_c = '0;
		for (int k = 0; k < 3; k++) begin
			qs = NORM_WIDTH'(quo[k]);
			n  = fin.neg[k] ? -qs : qs;
			// centre inside the box: fixed up normal
			if (fin.zero)
				n = (k == 1) ? NORM_ONE : '0;
			if (fin.sec)
				n = -n;
			if (fin.hit) begin
				res_c.nrm[k] = n;
				res_c.con[k] = fin.con[k];
			end
		end
		res_c.hit = fin.hit;
		res_c.pen = fin.hit ? fin.pen : '0;
	end

	// ---------------- output register plus skid ----------------
	logic out_valid_q;
	res_t out_q;
	res_t skid_q;
	logic push, pop;

	assign push = ce && fin_valid;
	assign pop  = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.hit;
	assign m_axis_tdata  = OUT_W'({out_q.con, out_q.nrm, out_q.pen});

`ifndef ASSERT_OFF
	// skid only fills behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds data while output register is empty");

	// a miss carries all-zero results
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss result carries nonzero fields");

	// a hit always has positive penetration
	a_hit_pen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (out_q.pen != '0))
		else $error("hit with zero penetration");

	// a result pushed while the output stalls lands in the skid
	a_stall_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && push) |=> skid_valid_q)
		else $error("result lost on output stall");
`endif

endmodule
